/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the region table checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRTC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define PRTC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/prtc_pkg.sv */
// ----------------------------------------------------------------------------
// prtc_pkg
// Types and constants shared by the region table checker and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package prtc_pkg;

  localparam int unsigned ENTRY_COUNT = 16;
  localparam int unsigned ENTRY_W     = 4;
  localparam int unsigned LIVE_W      = 5;
  localparam int unsigned ADDR_W      = 32;

  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef enum logic [2:0] {
    OP_SET       = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_LOCK      = 3'd2,
    OP_CHECK     = 3'd3,
    OP_GET       = 3'd4,
    OP_CLEAR_ALL = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_LOCKED  = 2'd2
  } status_e;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TOR   = 2'd1;
  localparam logic [1:0] MODE_NA4   = 2'd2;
  localparam logic [1:0] MODE_NAPOT = 2'd3;

  // One operation word as it travels down the row of cells, together with
  // the result fields the cells fill in on the way.
  typedef struct packed {
    logic                vld;
    op_e                 op;
    logic [ENTRY_W-1:0]  entry;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   size;
    logic [2:0]          perms;
    logic [1:0]          mode;
    logic [ADDR_W-1:0]   addr;
    logic                entry_ok;
    logic                napot_ok;
    logic [1:0]          status;
    logic                granted;
    logic                found;
    logic [ENTRY_W-1:0]  match_idx;
    logic [ADDR_W-1:0]   rd_base;
    logic [ADDR_W-1:0]   rd_size;
    logic [2:0]          rd_perms;
    logic [1:0]          rd_mode;
    logic                rd_active;
    logic                rd_locked;
  } tok_t;

endpackage

`default_nettype wire

/* src/prtc_cell.sv */
// ----------------------------------------------------------------------------
// prtc_cell
// One table entry. Applies the passing word to its own entry and hands the
// word on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prtc_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [prtc_pkg::ENTRY_W-1:0]   idx_i,
  input  wire logic [prtc_pkg::LIVE_W-1:0]    live_n_i,
  input  wire prtc_pkg::tok_t                 tok_i,
  output prtc_pkg::tok_t                      tok_o
);

  logic [prtc_pkg::ADDR_W-1:0] base_q, base_d;
  logic [prtc_pkg::ADDR_W-1:0] size_q, size_d;
  logic [2:0]                  perm_q, perm_d;
  logic [1:0]                  mode_q, mode_d;
  logic                        active_q, active_d;
  logic                        lock_q, lock_d;
  logic                        vld_q;
  prtc_pkg::tok_t              tok_q, tok_d;

  logic                        sel;
  logic                        live;
  logic                        hit;
  logic [prtc_pkg::ADDR_W:0]   lo;
  logic [prtc_pkg::ADDR_W:0]   hi;
  logic [prtc_pkg::ADDR_W:0]   a;

  assign sel  = tok_i.entry_ok && (tok_i.entry == idx_i);
  assign live = ({1'b0, idx_i} < live_n_i);

  // The upper bound is formed one bit wider so a region never wraps.
  assign lo  = {1'b0, base_q};
  assign hi  = {1'b0, base_q} + {1'b0, size_q};
  assign a   = {1'b0, tok_i.addr};
  assign hit = active_q && (a >= lo) && (a < hi);

  always_comb begin
    tok_d    = tok_i;
    base_d   = base_q;
    size_d   = size_q;
    perm_d   = perm_q;
    mode_d   = mode_q;
    active_d = active_q;
    lock_d   = lock_q;
    if (tok_i.vld) begin
      case (tok_i.op)
        prtc_pkg::OP_SET: begin
          if (sel) begin
            if (lock_q) begin
              tok_d.status = prtc_pkg::ST_LOCKED;
            end else if (tok_i.mode == prtc_pkg::MODE_NAPOT && !tok_i.napot_ok) begin
              tok_d.status = prtc_pkg::ST_INVALID;
            end else begin
              base_d   = tok_i.base;
              size_d   = tok_i.size;
              perm_d   = tok_i.perms;
              mode_d   = tok_i.mode;
              active_d = 1'b1;
            end
          end
        end
        prtc_pkg::OP_CLEAR: begin
          if (sel) begin
            if (lock_q) begin
              tok_d.status = prtc_pkg::ST_LOCKED;
            end else begin
              base_d   = '0;
              size_d   = '0;
              perm_d   = '0;
              active_d = 1'b0;
            end
          end
        end
        prtc_pkg::OP_LOCK: begin
          if (sel) begin
            lock_d = 1'b1;
          end
        end
        prtc_pkg::OP_CHECK: begin
          // Cells are visited in ascending order, so the first hit wins.
          if (live && hit && !tok_i.found) begin
            tok_d.found     = 1'b1;
            tok_d.match_idx = idx_i;
            tok_d.granted   = ((perm_q & tok_i.perms) == tok_i.perms);
          end
        end
        prtc_pkg::OP_GET: begin
          if (sel) begin
            tok_d.rd_base   = base_q;
            tok_d.rd_size   = size_q;
            tok_d.rd_perms  = perm_q;
            tok_d.rd_mode   = mode_q;
            tok_d.rd_active = active_q;
            tok_d.rd_locked = lock_q;
          end
        end
        prtc_pkg::OP_CLEAR_ALL: begin
          if (live && !lock_q) begin
            active_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      size_q   <= '0;
      perm_q   <= '0;
      mode_q   <= '0;
      active_q <= 1'b0;
      lock_q   <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      base_q   <= base_d;
      size_q   <= size_d;
      perm_q   <= perm_d;
      mode_q   <= mode_d;
      active_q <= active_d;
      lock_q   <= lock_d;
      vld_q    <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = vld_q;
  end

endmodule

`default_nettype wire

/* src/pmp_region_table_checker.sv */
// ----------------------------------------------------------------------------
// pmp_region_table_checker
// Memory protection region table with set, clear, lock, check, get and
// clear-all operations.
// ----------------------------------------------------------------------------
// Each of the 16 entries lives in its own cell of a row; an accepted word is
// registered once, then passes one cell per cycle, each cell updating its own
// entry or adding its part of the result, and lands in the output register.
// One word is in the row at a time, and the next word is taken once the result
// has been handed off.
`default_nettype none
`include "assert_macros.svh"

module pmp_region_table_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [2:0]   op_i,
  input  wire logic [3:0]   entry_i,
  input  wire logic [31:0]  region_start_i,
  input  wire logic [31:0]  region_length_i,
  input  wire logic [2:0]   perm_bits_i,
  input  wire logic [1:0]   match_mode_i,
  input  wire logic [31:0]  access_address_i,
  // output channel
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        status_o,
  output logic              granted_o,
  output logic              match_found_o,
  output logic [3:0]        match_index_o,
  output logic [31:0]       encoded_address_o,
  output logic [7:0]        cfg_byte_o,
  output logic [31:0]       read_base_o,
  output logic [31:0]       read_size_o,
  output logic [2:0]        read_perms_o,
  output logic [1:0]        read_mode_o,
  output logic              read_active_o,
  output logic              read_locked_o
);

  localparam int unsigned N = prtc_pkg::ENTRY_COUNT;

  logic [prtc_pkg::LIVE_W-1:0] entries_q;
  logic [prtc_pkg::LIVE_W-1:0] live_n;
  logic                        cfg_wr;

  logic                        in_acc;
  logic                        out_acc;
  logic                        inflight_q;
  logic                        launch_vld_q;
  prtc_pkg::tok_t              launch_q, launch_d;
  prtc_pkg::tok_t              chain [0:N];
  prtc_pkg::tok_t              last;
  logic [N:0]                  vld_vec;

  logic                        entry_ok;
  logic                        napot_ok;
  logic [31:0]                 enc;
  logic [7:0]                  cfg;

  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic                        granted_q;
  logic                        found_q;
  logic [3:0]                  index_q;
  logic [31:0]                 enc_q;
  logic [7:0]                  cfg_q;
  logic [31:0]                 rd_base_q;
  logic [31:0]                 rd_size_q;
  logic [2:0]                  rd_perms_q;
  logic [1:0]                  rd_mode_q;
  logic                        rd_active_q;
  logic                        rd_locked_q;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == prtc_pkg::REG_ENTRIES_IN_USE);
  assign prdata = (paddr[2] == prtc_pkg::REG_ENTRIES_IN_USE)
                  ? {{(32 - prtc_pkg::LIVE_W){1'b0}}, entries_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= prtc_pkg::LIVE_W'(N);
    end else if (cfg_wr) begin
      entries_q <= pwdata[prtc_pkg::LIVE_W-1:0];
    end
  end

  assign live_n = (entries_q > prtc_pkg::LIVE_W'(N)) ? prtc_pkg::LIVE_W'(N) : entries_q;

  // Handshakes.
  assign in_stall_o = inflight_q || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // Launch word.
  assign entry_ok = ({1'b0, entry_i} < live_n);
  assign napot_ok = (region_length_i >= 32'd8) &&
                    ((region_length_i & (region_length_i - 32'd1)) == '0);

  always_comb begin
    launch_d          = '0;
    launch_d.vld      = 1'b1;
    launch_d.op       = prtc_pkg::op_e'(op_i);
    launch_d.entry    = entry_i;
    launch_d.base     = region_start_i;
    launch_d.size     = region_length_i;
    launch_d.perms    = perm_bits_i;
    launch_d.mode     = match_mode_i;
    launch_d.addr     = access_address_i;
    launch_d.entry_ok = entry_ok;
    launch_d.napot_ok = napot_ok;
    case (prtc_pkg::op_e'(op_i))
      prtc_pkg::OP_SET, prtc_pkg::OP_CLEAR, prtc_pkg::OP_LOCK, prtc_pkg::OP_GET: begin
        launch_d.status = entry_ok ? prtc_pkg::ST_OK : prtc_pkg::ST_INVALID;
      end
      prtc_pkg::OP_CHECK, prtc_pkg::OP_CLEAR_ALL: begin
        launch_d.status = prtc_pkg::ST_OK;
      end
      default: begin
        launch_d.status = prtc_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_vld_q <= 1'b0;
      inflight_q   <= 1'b0;
    end else begin
      launch_vld_q <= in_acc;
      if (in_acc) begin
        inflight_q <= 1'b1;
      end else if (last.vld) begin
        inflight_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      launch_q <= launch_d;
    end
  end

  always_comb begin
    chain[0]     = launch_q;
    chain[0].vld = launch_vld_q;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    prtc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (prtc_pkg::ENTRY_W'(k)),
      .live_n_i (live_n),
      .tok_i    (chain[k]),
      .tok_o    (chain[k+1])
    );
  end

  assign last = chain[N];

  for (genvar k = 0; k <= N; k++) begin : g_vld
    assign vld_vec[k] = chain[k].vld;
  end

  // A successful set reports the address register value and config byte it encoded.
  always_comb begin
    enc = '0;
    cfg = '0;
    if (last.op == prtc_pkg::OP_SET && last.status == prtc_pkg::ST_OK) begin
      case (last.mode)
        prtc_pkg::MODE_TOR:   enc = (last.base + last.size) >> 2;
        prtc_pkg::MODE_NA4:   enc = last.base >> 2;
        prtc_pkg::MODE_NAPOT: enc = (last.base >> 2) | ((last.size >> 3) - 32'd1);
        default:              enc = '0;
      endcase
      cfg = {3'b000, last.mode, last.perms};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last.vld) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.vld) begin
      status_q    <= last.status;
      granted_q   <= last.granted;
      found_q     <= last.found;
      index_q     <= last.match_idx;
      enc_q       <= enc;
      cfg_q       <= cfg;
      rd_base_q   <= last.rd_base;
      rd_size_q   <= last.rd_size;
      rd_perms_q  <= last.rd_perms;
      rd_mode_q   <= last.rd_mode;
      rd_active_q <= last.rd_active;
      rd_locked_q <= last.rd_locked;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_o         = granted_q;
  assign match_found_o     = found_q;
  assign match_index_o     = index_q;
  assign encoded_address_o = enc_q;
  assign cfg_byte_o        = cfg_q;
  assign read_base_o       = rd_base_q;
  assign read_size_o       = rd_size_q;
  assign read_perms_o      = rd_perms_q;
  assign read_mode_o       = rd_mode_q;
  assign read_active_o     = rd_active_q;
  assign read_locked_o     = rd_locked_q;

  `PRTC_ASSERT_NEXT(a_accept_marks_busy, clk_i, rst_ni, in_acc, inflight_q)
  `PRTC_ASSERT(a_busy_excl_result, clk_i, rst_ni, !(inflight_q && out_valid_q))
  `PRTC_ASSERT(a_single_word, clk_i, rst_ni, $onehot0(vld_vec))
  `PRTC_ASSERT(a_no_overwrite, clk_i, rst_ni, !(last.vld && out_valid_q))

endmodule

`default_nettype wire
